/* rtl/iprl_pkg.sv */
// ----------------------------------------------------------------------------
// iprl_pkg
// Shared types and constants for the incremental PI duty regulator.
// ----------------------------------------------------------------------------
package iprl_pkg;

  localparam int SPEED_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int GAIN_BITS = 16;
  localparam int GAIN_FRAC = 16;
  localparam int DUTY_BITS = 10;

  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;

  localparam logic [GAIN_BITS-1:0] KP_GAIN_RESET    = 16'd1311;
  localparam logic [GAIN_BITS-1:0] KI_GAIN_RESET    = 16'd164;
  localparam logic [DUTY_BITS-1:0] DUTY_MIN_RESET   = 10'd50;
  localparam logic [DUTY_BITS-1:0] DUTY_MAX_RESET   = 10'd110;
  localparam logic [DUTY_BITS-1:0] RISE_LIMIT_RESET = 10'd2;
  localparam logic [DUTY_BITS-1:0] FALL_LIMIT_RESET = 10'd5;
  localparam logic [DUTY_BITS-1:0] DUTY_ACC_RESET   = 10'd50;

  typedef enum logic [2:0] {
    REG_KP_GAIN    = 3'd0,
    REG_KI_GAIN    = 3'd1,
    REG_DUTY_MIN   = 3'd2,
    REG_DUTY_MAX   = 3'd3,
    REG_RISE_LIMIT = 3'd4,
    REG_FALL_LIMIT = 3'd5
  } reg_idx_t;

  typedef enum logic {
    REQ_STEP  = 1'b0,
    REQ_RESET = 1'b1
  } req_t;

endpackage

/* rtl/incremental_pi_rate_limited_unit.sv */
// ----------------------------------------------------------------------------
// incremental_pi_rate_limited_unit
// Velocity-form PI duty regulator with rate limit and duty clamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per transaction:
//   a control step (target and measured speed) or a reload with an initial
//   duty. Output channel (out_valid / out_stall) returns exactly one result
//   per request, in order: duty_out, rate_limited and duty_clamped.
//   Gains, duty limits and rate limits sit on an APB port at 4*index and
//   should be written while no request is in flight.
//   A request taken lands in the input register; from there the step is
//   computed and loaded into the result register together with the error
//   and accumulator state. Throughput is one request per cycle while the
//   receiver does not stall; the path from the state registers through the
//   gain multipliers, rate limit, accumulator add and clamp sets that figure.
//   Reset clears both stages, loads the register defaults, sets the duty
//   accumulator to 50 and clears the kept error; in_stall is high during reset.
//   When the receiver stalls, the result holds, one more request is taken
//   into the input register, and in_stall then rises until the result drains.
// ----------------------------------------------------------------------------
module incremental_pi_rate_limited_unit #(
  parameter int SPEED_BITS = iprl_pkg::SPEED_BITS_DEF,
  parameter int FRAC_BITS  = iprl_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [iprl_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [iprl_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [iprl_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [SPEED_BITS-1:0]               target_speed,
  input  logic [SPEED_BITS-1:0]               measured_speed,
  input  logic [iprl_pkg::DUTY_BITS-1:0]      initial_duty,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [iprl_pkg::DUTY_BITS-1:0]      duty_out,
  output logic                                rate_limited,
  output logic                                duty_clamped
);
  import iprl_pkg::*;

  localparam int E_W   = SPEED_BITS + 1;
  localparam int D_W   = E_W + 1;
  localparam int P_W   = GAIN_BITS + 1 + D_W;
  localparam int I_W   = GAIN_BITS + 1 + E_W;
  localparam int SUM_W = P_W + 1;
  localparam int DEL_W = SUM_W + FRAC_BITS;
  localparam int ACC_W = DUTY_BITS + FRAC_BITS;
  localparam int SUMA_W = ACC_W + 2;
  localparam int SHL   = (FRAC_BITS >= GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
  localparam int SHR   = (FRAC_BITS >= GAIN_FRAC) ? 0 : GAIN_FRAC - FRAC_BITS;
  localparam logic [ACC_W:0] HALF = (ACC_W+1)'(1) << (FRAC_BITS - 1);

  // configuration registers
  logic [GAIN_BITS-1:0] kp_gain;
  logic [GAIN_BITS-1:0] ki_gain;
  logic [DUTY_BITS-1:0] duty_min;
  logic [DUTY_BITS-1:0] duty_max;
  logic [DUTY_BITS-1:0] rise_limit;
  logic [DUTY_BITS-1:0] fall_limit;

  reg_idx_t reg_sel;
  logic     cfg_write;

  assign reg_sel   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain    <= KP_GAIN_RESET;
      ki_gain    <= KI_GAIN_RESET;
      duty_min   <= DUTY_MIN_RESET;
      duty_max   <= DUTY_MAX_RESET;
      rise_limit <= RISE_LIMIT_RESET;
      fall_limit <= FALL_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_KP_GAIN:    kp_gain    <= pwdata[GAIN_BITS-1:0];
        REG_KI_GAIN:    ki_gain    <= pwdata[GAIN_BITS-1:0];
        REG_DUTY_MIN:   duty_min   <= pwdata[DUTY_BITS-1:0];
        REG_DUTY_MAX:   duty_max   <= pwdata[DUTY_BITS-1:0];
        REG_RISE_LIMIT: rise_limit <= pwdata[DUTY_BITS-1:0];
        REG_FALL_LIMIT: fall_limit <= pwdata[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KP_GAIN:    prdata = APB_DATA_BITS'(kp_gain);
      REG_KI_GAIN:    prdata = APB_DATA_BITS'(ki_gain);
      REG_DUTY_MIN:   prdata = APB_DATA_BITS'(duty_min);
      REG_DUTY_MAX:   prdata = APB_DATA_BITS'(duty_max);
      REG_RISE_LIMIT: prdata = APB_DATA_BITS'(rise_limit);
      REG_FALL_LIMIT: prdata = APB_DATA_BITS'(fall_limit);
      default:        prdata = '0;
    endcase
  end

  // input register
  logic                  s1_valid;
  logic                  s1_req_type;
  logic [SPEED_BITS-1:0] s1_target;
  logic [SPEED_BITS-1:0] s1_measured;
  logic [DUTY_BITS-1:0]  s1_initial;

  logic out_free;
  logic s1_move;
  logic in_take;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = rst || (s1_valid && !out_free);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_type <= req_type;
      s1_target   <= target_speed;
      s1_measured <= measured_speed;
      s1_initial  <= initial_duty;
    end
  end

  // regulator state
  logic signed [E_W-1:0] previous_error;
  logic [ACC_W-1:0]      duty_accumulator;

  // step datapath
  logic signed [E_W-1:0]    err;
  logic signed [D_W-1:0]    derr;
  logic signed [P_W-1:0]    p_prod;
  logic signed [I_W-1:0]    i_prod;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DEL_W-1:0]  sum_x;
  logic signed [DEL_W-1:0]  delta;
  logic signed [DEL_W-1:0]  up_lim;
  logic signed [DEL_W-1:0]  down_lim;
  logic signed [DEL_W-1:0]  lim_delta;
  logic signed [SUMA_W-1:0] acc_sum;
  logic signed [SUMA_W-1:0] max_q;
  logic signed [SUMA_W-1:0] min_q;
  logic [ACC_W:0]           rnd;
  logic [DUTY_BITS-1:0]     init_clamped;

  logic signed [E_W-1:0] previous_error_next;
  logic [ACC_W-1:0]      duty_accumulator_next;
  logic [DUTY_BITS-1:0]  duty_out_next;
  logic                  rate_limited_next;
  logic                  duty_clamped_next;

  always_comb begin
    err    = $signed({1'b0, s1_target}) - $signed({1'b0, s1_measured});
    derr   = $signed({err[E_W-1], err}) - $signed({previous_error[E_W-1], previous_error});
    p_prod = $signed({1'b0, kp_gain}) * derr;
    i_prod = $signed({1'b0, ki_gain}) * err;
    sum    = SUM_W'(p_prod) + SUM_W'(i_prod);
    // bring the Q.16 sum to the accumulator format, floor on a right shift
    sum_x  = DEL_W'(sum);
    delta  = (sum_x <<< SHL) >>> SHR;

    up_lim   = $signed(DEL_W'({rise_limit, {FRAC_BITS{1'b0}}}));
    down_lim = -$signed(DEL_W'({fall_limit, {FRAC_BITS{1'b0}}}));

    rate_limited_next = 1'b0;
    if (delta > up_lim) begin
      lim_delta         = up_lim;
      rate_limited_next = 1'b1;
    end else if (delta < down_lim) begin
      lim_delta         = down_lim;
      rate_limited_next = 1'b1;
    end else begin
      lim_delta = delta;
    end

    acc_sum = $signed({2'b00, duty_accumulator}) + SUMA_W'(lim_delta);
    max_q   = $signed({2'b00, duty_max, {FRAC_BITS{1'b0}}});
    min_q   = $signed({2'b00, duty_min, {FRAC_BITS{1'b0}}});

    // max is tested first, so an inverted pair still settles
    duty_clamped_next = 1'b0;
    if (acc_sum > max_q) begin
      duty_accumulator_next = ACC_W'(max_q);
      duty_clamped_next     = 1'b1;
    end else if (acc_sum < min_q) begin
      duty_accumulator_next = ACC_W'(min_q);
      duty_clamped_next     = 1'b1;
    end else begin
      duty_accumulator_next = ACC_W'(acc_sum);
    end

    rnd                 = {1'b0, duty_accumulator_next} + HALF;
    duty_out_next       = rnd[FRAC_BITS +: DUTY_BITS];
    previous_error_next = err;

    // reload: clamp the initial duty, min wins
    init_clamped = s1_initial;
    if (s1_req_type == REQ_RESET) begin
      duty_clamped_next = 1'b0;
      if (init_clamped > duty_max) begin
        init_clamped      = duty_max;
        duty_clamped_next = 1'b1;
      end
      if (init_clamped < duty_min) begin
        init_clamped      = duty_min;
        duty_clamped_next = 1'b1;
      end
      rate_limited_next     = 1'b0;
      previous_error_next   = '0;
      duty_accumulator_next = {init_clamped, {FRAC_BITS{1'b0}}};
      duty_out_next         = init_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      previous_error   <= '0;
      duty_accumulator <= {DUTY_ACC_RESET, {FRAC_BITS{1'b0}}};
    end else begin
      if (s1_move) begin
        out_valid        <= 1'b1;
        previous_error   <= previous_error_next;
        duty_accumulator <= duty_accumulator_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      duty_out     <= duty_out_next;
      rate_limited <= rate_limited_next;
      duty_clamped <= duty_clamped_next;
    end
  end

endmodule

/* rtl/iprl_check.sv */
// ----------------------------------------------------------------------------
// iprl_check
// Port-level checks for the incremental PI duty regulator, bound to the top.
// ----------------------------------------------------------------------------
module iprl_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [iprl_pkg::DUTY_BITS-1:0] duty_out,
  input logic                           rate_limited,
  input logic                           duty_clamped
);
  import iprl_pkg::*;

  // a held result keeps its fields
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(duty_out)
      && $stable(rate_limited) && $stable(duty_clamped))
    else $error("result changed while stalled");

  // back-pressure only when the result register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  // a fresh result follows an earlier transaction taken into the input register
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a transaction");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind incremental_pi_rate_limited_unit iprl_check u_iprl_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .duty_out     (duty_out),
  .rate_limited (rate_limited),
  .duty_clamped (duty_clamped)
);
